### src/mrms_pkg.sv
// Package for the masked range memory scan block.
// Holds the channel payload types, the queue entry type, register indexes
// and the element extraction helpers. Depends on nothing.
`default_nettype none

package mrms_pkg;

   // Request beat: one memory word or an end-of-scan marker.
   typedef struct packed {
      logic [63:0] word_addr;
      logic [63:0] word_data;
      logic        readable;
      logic        end_of_scan;
   } req_type;

   // Response beat: one match report or one summary.
   typedef struct packed {
      logic        kind;
      logic [63:0] match_addr;
      logic [63:0] match_value;
      logic        searched_any;
      logic        last;
   } rsp_type;

   // Classified work item passed from the front end to the back end.
   typedef struct packed {
      logic        is_end;
      logic        searched;
      logic [7:0]  hits;
      logic [63:0] base;
      logic [63:0] data;
      logic [1:0]  size_log2;
      logic        big_endian;
   } entry_type;

   // Result kinds.
   localparam logic KindMatch   = 1'b0;
   localparam logic KindSummary = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CsrPattern   = 3'd0;
   localparam logic [2:0] CsrMatchMask = 3'd1;
   localparam logic [2:0] CsrDistance  = 3'd2;
   localparam logic [2:0] CsrMinAddr   = 3'd3;
   localparam logic [2:0] CsrMaxAddr   = 3'd4;
   localparam logic [2:0] CsrElemSize  = 3'd5;
   localparam logic [2:0] CsrBigEndian = 3'd6;

   // Queue between front and back end.
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   // Mask of the bits that belong to one element.
   function automatic logic [63:0] elem_mask(input logic [1:0] size_log2);
      logic [63:0] m;
      case (size_log2)
         2'd0:    m = 64'h0000_0000_0000_00ff;
         2'd1:    m = 64'h0000_0000_0000_ffff;
         2'd2:    m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   // Byte offset of a lane within the word.
   function automatic logic [2:0] lane_offset(input logic [2:0] lane,
                                              input logic [1:0] size_log2);
      logic [3:0] off;
      off = {1'b0, lane} << size_log2;
      return off[2:0];
   endfunction

   // Value of one lane, zero extended, honoring the byte order.
   function automatic logic [63:0] elem_at(input logic [63:0] data,
                                           input logic [2:0]  lane,
                                           input logic [1:0]  size_log2,
                                           input logic        big_end);
      logic [3:0]  off;
      logic [3:0]  size;
      logic [3:0]  sh;
      logic [63:0] shifted;
      size = 4'd1 << size_log2;
      off = {1'b0, lane_offset(lane, size_log2)};
      sh = big_end ? (4'd8 - off - size) : off;
      shifted = data >> {sh[2:0], 3'b000};
      return shifted & elem_mask(size_log2);
   endfunction

endpackage

`default_nettype wire

### src/masked_range_memory_scan_top.sv
// Masked range memory scan, top level.
// Connects the front end, the entry queue and the back end. Depends on
// mrms_pkg, mrms_front, mrms_queue and mrms_back.
//
// Usage: the req channel carries one aligned 64-bit memory word per beat
// (address, data, readable flag) or an end-of-scan marker. The rsp channel
// returns one beat per matching element in address order, with last set on
// the final beat of each word, and one summary beat per end-of-scan marker.
// Words that are unreadable or have no matching element give no beat.
// The csr channel writes the search registers; it is always ready. The user
// must write it only while the block is idle; the block does not enforce it.
// With the response register free, the first response beat of a request
// passes through the entry queue and then the response register.
// Throughput: one request beat per cycle while each word has at most one
// match and the receiver is ready; a word with several matches occupies the
// back end for one beat per match, through the single response register.
// A four-entry queue lets the front end keep accepting words while the back
// end drains matches. When the receiver stalls, the response register holds
// its beat and the queue fills; req_ready drops only when the queue is full.
// Reset (synchronous) empties the queue, drops rsp_valid, clears the
// scan-seen flag and returns the registers to their reset values.
`default_nettype none

module masked_range_memory_scan_top #(
   parameter int ADDR_BITS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire mrms_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mrms_pkg::rsp_type       rsp_payload,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);
   import mrms_pkg::*;

   logic      push, pop, full, not_empty;
   entry_type push_entry, head;

   mrms_front #(
      .ADDR_BITS(ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   mrms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   mrms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

### src/mrms_front.sv
// Front end of the masked range memory scan: configuration registers,
// request acceptance and per-lane match classification.
// Depends on mrms_pkg.
`default_nettype none

module mrms_front #(
   parameter int ADDR_BITS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire mrms_pkg::req_type  req_payload,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata,
   input  wire logic               queue_full,
   output logic                    push,
   output mrms_pkg::entry_type     push_entry
);
   import mrms_pkg::*;

   localparam logic [63:0] AddrMask = {64{1'b1}} >> (64 - ADDR_BITS);

   logic [63:0] pattern_ff, pattern_in;
   logic [63:0] mask_ff, mask_in;
   logic [63:0] dist_ff, dist_in;
   logic [63:0] min_ff, min_in;
   logic [63:0] max_ff, max_in;
   logic [1:0]  size_log2_ff, size_log2_in;
   logic        big_end_ff, big_end_in;
   logic        seen_ff, seen_in;

   logic        accept;
   logic        is_word;
   logic [63:0] emask, pat, msk, span, lo, hi, size64, base;
   logic [3:0]  lane_count;
   logic [7:0]  hits;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Configuration register writes.
   always_comb begin
      pattern_in   = pattern_ff;
      mask_in      = mask_ff;
      dist_in      = dist_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      size_log2_in = size_log2_ff;
      big_end_in   = big_end_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrPattern:   pattern_in   = csr_wdata;
            CsrMatchMask: mask_in      = csr_wdata;
            CsrDistance:  dist_in      = csr_wdata;
            CsrMinAddr:   min_in       = csr_wdata;
            CsrMaxAddr:   max_in       = csr_wdata;
            CsrElemSize:  size_log2_in = csr_wdata[1:0];
            CsrBigEndian: big_end_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Scan-seen flag: set by a readable word, cleared by an end-of-scan beat.
   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (req_payload.end_of_scan) begin
            seen_in = 1'b0;
         end else if (req_payload.readable) begin
            seen_in = 1'b1;
         end
      end
   end

   // Per-lane classification; the lanes are independent of each other.
   always_comb begin
      emask      = elem_mask(size_log2_ff);
      pat        = pattern_ff & emask;
      msk        = mask_ff & emask;
      span       = dist_ff & emask;
      lo         = min_ff & AddrMask;
      hi         = max_ff & AddrMask;
      size64     = 64'd1 << size_log2_ff;
      base       = req_payload.word_addr & AddrMask & ~64'd7;
      lane_count = 4'd8 >> size_log2_ff;
      is_word    = req_payload.readable && !req_payload.end_of_scan;
      for (int i = 0; i < 8; i++) begin
         logic [63:0] cur;
         logic [63:0] ea;
         logic        value_hit;
         logic        addr_ok;
         cur = elem_at(req_payload.word_data, 3'(i), size_log2_ff, big_end_ff);
         ea  = base | 64'(lane_offset(3'(i), size_log2_ff));
         value_hit = (((cur ^ pat) & msk) == 64'd0) || (((cur - pat) & emask) < span);
         addr_ok = (ea >= lo) && ((hi == 64'd0) || ((hi >= size64) && (ea <= hi - size64)));
         hits[i] = is_word && (4'(i) < lane_count) && value_hit && addr_ok;
      end
   end

   // Queue entry: summaries always, words only when a lane hit.
   always_comb begin
      push_entry.is_end     = req_payload.end_of_scan;
      push_entry.searched   = seen_ff;
      push_entry.hits       = hits;
      push_entry.base       = base;
      push_entry.data       = req_payload.word_data;
      push_entry.size_log2  = size_log2_ff;
      push_entry.big_endian = big_end_ff;
      push = accept && (req_payload.end_of_scan || (hits != 8'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= 64'd0;
         mask_ff      <= {64{1'b1}};
         dist_ff      <= 64'd0;
         min_ff       <= 64'd0;
         max_ff       <= 64'd0;
         size_log2_ff <= 2'd3;
         big_end_ff   <= 1'b0;
         seen_ff      <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         mask_ff      <= mask_in;
         dist_ff      <= dist_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         size_log2_ff <= size_log2_in;
         big_end_ff   <= big_end_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

`default_nettype wire

### src/mrms_queue.sv
// Short show-ahead queue of classified entries between front and back end.
// Depends on mrms_pkg.
`default_nettype none

module mrms_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire mrms_pkg::entry_type push_entry,
   input  wire logic                pop,
   output logic                     full,
   output logic                     not_empty,
   output mrms_pkg::entry_type      head
);
   import mrms_pkg::*;

   entry_type                 store [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrBits:0]     count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = count_ff == (QueuePtrBits + 1)'(QueueDepth);
   assign not_empty = count_ff != '0;
   assign head      = store[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign do_push   = push && !full;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### src/mrms_back.sv
// Back end of the masked range memory scan: walks the hit lanes of the
// queue head one per cycle while the receiver is ready and drives the
// registered response channel. Depends on mrms_pkg.
`default_nettype none

module mrms_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire mrms_pkg::entry_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output mrms_pkg::rsp_type        rsp_payload
);
   import mrms_pkg::*;

   logic       busy_ff, busy_in;
   logic [7:0] rem_ff, rem_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;

   logic       load;
   logic [7:0] mask_now, rest;
   logic [2:0] lane;

   assign load        = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

   // Lowest remaining hit lane of the head entry.
   always_comb begin
      mask_now = busy_ff ? rem_ff : head.hits;
      lane = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (mask_now[i]) begin
            lane = 3'(i);
         end
      end
      rest = mask_now & ~(8'd1 << lane);
   end

   // Next response beat and head retirement.
   always_comb begin
      busy_in  = busy_ff;
      rem_in   = rem_ff;
      out_in   = out_ff;
      pop      = 1'b0;
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
         if (head.is_end) begin
            out_in.kind         = KindSummary;
            out_in.match_addr   = 64'd0;
            out_in.match_value  = 64'd0;
            out_in.searched_any = head.searched;
            out_in.last         = 1'b1;
            pop                 = 1'b1;
            busy_in             = 1'b0;
         end else begin
            out_in.kind         = KindMatch;
            out_in.match_addr   = head.base | 64'(lane_offset(lane, head.size_log2));
            out_in.match_value  = elem_at(head.data, lane, head.size_log2,
                                          head.big_endian);
            out_in.searched_any = 1'b0;
            out_in.last         = rest == 8'd0;
            pop                 = rest == 8'd0;
            busy_in             = rest != 8'd0;
            rem_in              = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      out_ff <= out_in;
   end

endmodule

`default_nettype wire
